/* hw/rtl/umpq_pkg.sv */
// umpq_pkg: command and status codes, field widths and defaults for the
// unsorted max priority queue. No dependencies; used by the top level.
`timescale 1ns / 1ps

package umpq_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam int VALUE_W  = 32;
   localparam int OCC_W    = 7;
   localparam int REQ_TDATA_W = 32;  // value
   localparam int REQ_TUSER_W = 2;   // command
   localparam int RSP_TDATA_W = 40;  // result_value, occupancy, padded
   localparam int RSP_TUSER_W = 3;   // result_valid, status

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_TOP  = 2'd1,
      CMD_POP  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_DRAIN  = 6'b000100,
      S_FINISH = 6'b001000,
      S_LAST   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

endpackage

/* hw/rtl/unsorted_max_priority_queue_top.sv */
// unsorted_max_priority_queue_top: priority queue over an unsorted value
// store, scanned by a single shared comparator. Depends on umpq_pkg.
//
// Usage:
//   req channel: one command per transfer. req_tuser holds the command
//   (push, top, pop), req_tdata the signed value used by push.
//   rsp channel: exactly one transfer per command, carrying the value found,
//   a valid flag, a status (ok, empty, full) and the occupancy afterwards.
//   Sequence: push, an empty top/pop and the unused command go from idle
//   straight to S_DONE, which loads the output register. Top scans all N
//   stored values (S_SCAN), then passes S_DRAIN and S_FINISH: the comparator
//   looks at one entry per cycle through the single memory read port. Pop
//   then passes S_LAST, moving the last entry into the freed slot.
//   Flow: one command at a time; req_tready is high only while the sequencer
//   is idle. A finished result waits in the output register while the next
//   is taken.
//   Stall: while rsp_tready is low the result holds; a following command
//   finishes its work and then waits until the output register is free.
//   Reset (synchronous, active high) empties the queue and drops any
//   pending result; the store contents are not cleared.
`timescale 1ns / 1ps

module unsorted_max_priority_queue_top #(
   parameter int CAPACITY = umpq_pkg::DEF_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [umpq_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [umpq_pkg::REQ_TUSER_W-1:0] req_tuser,  // [1:0] command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [umpq_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] result_value, [38:32] occupancy
   output logic [umpq_pkg::RSP_TUSER_W-1:0] rsp_tuser   // [0] result_valid, [2:1] status
);
   import umpq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // value store
   logic [VALUE_W-1:0] mem [CAPACITY];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [VALUE_W-1:0] rd_data_ff;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [VALUE_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               res_valid_ff, res_valid_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;

   logic               req_xfer;
   logic               out_free;
   logic [CNT_W-1:0]   count_m1;
   logic [IDX_W-1:0]   last_idx;
   logic               full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign count_m1   = count_ff - 1'b1;
   assign last_idx   = count_m1[IDX_W-1:0];
   assign full       = (count_ff == CNT_W'(CAPACITY));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      rd_idx_in     = addr_ff;
      rd_vld_in     = 1'b0;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      res_value_in  = res_value_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[IDX_W-1:0];
      mem_wdata     = req_tdata[VALUE_W-1:0];
      mem_raddr     = addr_ff;

      // shared comparator: first entry seeds, strictly greater replaces
      if (rd_vld_ff && ((rd_idx_ff == '0) || ($signed(rd_data_ff) > $signed(best_ff)))) begin
         best_in     = rd_data_ff;
         best_idx_in = rd_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in        = cmd_type'(req_tuser[1:0]);
               res_value_in  = '0;
               res_valid_in  = 1'b0;
               res_status_in = ST_OK;
               addr_in       = '0;
               state_in      = S_DONE;
               case (cmd_type'(req_tuser[1:0]))
                  CMD_PUSH: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_TOP, CMD_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            if (addr_ff == last_idx) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_value_in = best_ff;
            res_valid_in = 1'b1;
            if (cmd_ff == CMD_POP) begin
               mem_raddr = last_idx;
               state_in  = S_LAST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LAST: begin
            // last entry fills the slot of the removed maximum
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff;
            mem_wdata = rd_data_ff;
            count_in  = count_m1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_valid_in  = res_valid_ff;
               rsp_status_in = res_status_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      res_value_ff  <= res_value_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - OCC_W)'(0), rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_valid_ff};

endmodule
